// ===== hw/rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int DEF_STORE_BYTES = 8192;
  localparam int DEF_MAX_ROWS    = 32;
  localparam int DEF_MAX_WIDTH   = 8;

  // Raw glyph address before reduction: char_code * stride or a load address
  localparam int VW = 14;

  localparam int COLOR_W     = 24;
  localparam int COORD_W     = 13;
  localparam int NUM_PIX     = 8;
  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 224;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CURSOR = 2'd1;
  localparam logic [1:0] FUNC_AT     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SH = 3'd6;

  localparam logic [COLOR_W-1:0] RST_FG = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RST_BG = 24'h000000;
  localparam logic [3:0]         RST_GW = 4'd8;
  localparam logic [5:0]         RST_GH = 6'd16;
  localparam logic [5:0]         RST_GS = 6'd16;
  localparam logic [COORD_W-1:0] RST_SW = 13'd1024;
  localparam logic [COORD_W-1:0] RST_SH = 13'd768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_POS,
    ST_REDUCE,
    ST_ROWS
  } state_t;

  typedef struct packed {
    logic          start;
    logic [VW-1:0] value;
  } red_req_t;

endpackage

// ===== hw/rtl/bitmap_font_text_renderer.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer
// Glyph store and row generator: loads font bytes, draws characters as rows.
// ----------------------------------------------------------------------------
// Load: the address is reduced by a mask (power-of-two store) or a reciprocal
// reduce, then the byte is written. Draw: wrap, position, reduce, then one glyph
// row read from the store per cycle, held in stage 1, then the output register.
// Rejected character: one result, no read. Output stalls pause the row reads.
// Reset clears cursor, pipeline and registers to defaults; store is not cleared.
module bitmap_font_text_renderer import brf_pkg::*; #(
  parameter int STORE_BYTES = DEF_STORE_BYTES,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // char_code[7:0], store_address[20:8], store_byte[28:21],
  // at_column[41:29], at_line[54:42]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pixel_x[12:0], pixel_y[25:13], color_0[49:26] .. color_7[217:194]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // row_last
  output logic                   out_tlast,
  // drawn
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [AW-1:0] ADDR_TOP = AW'(STORE_BYTES - 1);

  logic [COLOR_W-1:0] fg_r, bg_r;
  logic [3:0]         gw_r;
  logic [5:0]         gh_r, gs_r;
  logic [COORD_W-1:0] sw_r, sh_r;

  state_t             state_r, state_nxt;
  logic [COORD_W-1:0] cur_col_r, cur_col_nxt;
  logic [COORD_W-1:0] cur_line_r, cur_line_nxt;
  logic               is_load_r, is_load_nxt;
  logic               is_cursor_r, is_cursor_nxt;
  logic [7:0]         code_r, code_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W:0]   line_r, line_nxt;
  logic [COORD_W-1:0] x0_r, x0_nxt;
  logic [19:0]        y0_r, y0_nxt;
  logic               reject_r, reject_nxt;
  logic [AW-1:0]      row_addr_r, row_addr_nxt;
  logic [RW-1:0]      row_r, row_nxt;

  logic               s1_v_r, s1_v_nxt;
  logic [COORD_W-1:0] s1_px_r, s1_px_nxt;
  logic [COORD_W-1:0] s1_py_r, s1_py_nxt;
  logic               s1_last_r, s1_last_nxt;
  logic               s1_drawn_r, s1_drawn_nxt;

  logic               o_v_r, o_v_nxt;
  logic [COORD_W-1:0] o_px_r, o_px_nxt;
  logic [COORD_W-1:0] o_py_r, o_py_nxt;
  logic [COLOR_W-1:0] o_col_r [NUM_PIX];
  logic [COLOR_W-1:0] o_col_nxt [NUM_PIX];
  logic               o_last_r, o_last_nxt;
  logic               o_drawn_r, o_drawn_nxt;

  logic [3:0]         eff_w;
  logic [5:0]         eff_h;
  logic               s1_move, issue;
  logic [COORD_W:0]   col_inc;
  logic [17:0]        wrap_prod;
  logic               wrap;
  logic [16:0]        x_prod;
  logic               mem_we, mem_re;
  logic [7:0]         mem_rdata;
  red_req_t           red_req;
  logic               red_done;
  logic [AW-1:0]      red_rem;
  logic [2:0]         sh;

  assign eff_w = (gw_r == 4'd0) ? 4'd1 : (gw_r > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : gw_r;
  assign eff_h = (gh_r == 6'd0) ? 6'd1 : (gh_r > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : gh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= RST_FG;
      bg_r <= RST_BG;
      gw_r <= RST_GW;
      gh_r <= RST_GH;
      gs_r <= RST_GS;
      sw_r <= RST_SW;
      sh_r <= RST_SH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG:  fg_r <= cfg_wdata;
        CFG_BG:  bg_r <= cfg_wdata;
        CFG_GW:  gw_r <= cfg_wdata[3:0];
        CFG_GH:  gh_r <= cfg_wdata[5:0];
        CFG_GS:  gs_r <= cfg_wdata[5:0];
        CFG_SW:  sw_r <= cfg_wdata[COORD_W-1:0];
        CFG_SH:  sh_r <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  brf_addr_reduce #(
    .STORE_BYTES(STORE_BYTES),
    .AW         (AW)
  ) u_reduce (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (red_req),
    .done (red_done),
    .rem  (red_rem)
  );

  brf_glyph_store #(
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(red_rem),
    .wdata(byte_r),
    .re   (mem_re),
    .raddr(row_addr_r),
    .rdata(mem_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign s1_move   = s1_v_r && (!o_v_r || out_tready);
  assign issue     = !s1_v_r || s1_move;
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign wrap_prod = 18'(col_inc) * 18'(eff_w);
  assign wrap      = wrap_prod >= 18'(sw_r);
  assign x_prod    = 17'(col_r) * 17'(eff_w);

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_line_nxt  = cur_line_r;
    is_load_nxt   = is_load_r;
    is_cursor_nxt = is_cursor_r;
    code_nxt      = code_r;
    byte_nxt      = byte_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    reject_nxt    = reject_r;
    row_addr_nxt  = row_addr_r;
    row_nxt       = row_r;
    red_req.start = 1'b0;
    red_req.value = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    s1_v_nxt      = s1_v_r && !s1_move;
    s1_px_nxt     = s1_px_r;
    s1_py_nxt     = s1_py_r;
    s1_last_nxt   = s1_last_r;
    s1_drawn_nxt  = s1_drawn_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          code_nxt = in_tdata[7:0];
          byte_nxt = in_tdata[28:21];
          case (in_tuser)
            FUNC_LOAD: begin
              is_load_nxt   = 1'b1;
              red_req.start = 1'b1;
              red_req.value = VW'(in_tdata[20:8]);
              state_nxt     = ST_REDUCE;
            end
            FUNC_CURSOR: begin
              is_load_nxt   = 1'b0;
              is_cursor_nxt = 1'b1;
              col_nxt       = cur_col_r;
              line_nxt      = {1'b0, cur_line_r};
              state_nxt     = ST_PREP;
            end
            FUNC_AT: begin
              is_load_nxt   = 1'b0;
              is_cursor_nxt = 1'b0;
              col_nxt       = in_tdata[41:29];
              line_nxt      = {1'b0, in_tdata[54:42]};
              state_nxt     = ST_PREP;
            end
            default: ;
          endcase
        end
      end
      ST_PREP: begin
        if (wrap) begin
          col_nxt  = '0;
          line_nxt = is_cursor_r ? {1'b0, line_r[COORD_W-1:0] + 1'b1} : line_r + 1'b1;
        end
        state_nxt = ST_POS;
      end
      ST_POS: begin
        x0_nxt     = x_prod[COORD_W-1:0];
        y0_nxt     = 20'(line_r) * 20'(eff_h);
        reject_nxt = y0_nxt >= 20'(sh_r);
        if (is_cursor_r) begin
          cur_line_nxt = line_r[COORD_W-1:0];
          cur_col_nxt  = reject_nxt ? col_r : col_r + 1'b1;
        end
        if (reject_nxt) begin
          state_nxt = ST_ROWS;
        end else begin
          red_req.start = 1'b1;
          red_req.value = VW'(code_r) * VW'(gs_r);
          state_nxt     = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (red_done) begin
          if (is_load_r) begin
            mem_we    = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            row_addr_nxt = red_rem;
            row_nxt      = '0;
            state_nxt    = ST_ROWS;
          end
        end
      end
      ST_ROWS: begin
        if (issue) begin
          mem_re       = !reject_r;
          s1_v_nxt     = 1'b1;
          s1_drawn_nxt = !reject_r;
          s1_px_nxt    = reject_r ? '0 : x0_r;
          s1_py_nxt    = reject_r ? '0 : y0_r[COORD_W-1:0] + COORD_W'(row_r);
          s1_last_nxt  = reject_r || (6'(row_r) + 6'd1 == eff_h);
          row_addr_nxt = (row_addr_r == ADDR_TOP) ? '0 : row_addr_r + 1'b1;
          row_nxt      = row_r + 1'b1;
          if (s1_last_nxt) begin
            reject_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    o_v_nxt     = (o_v_r && !out_tready) || s1_move;
    o_px_nxt    = o_px_r;
    o_py_nxt    = o_py_r;
    o_last_nxt  = o_last_r;
    o_drawn_nxt = o_drawn_r;
    sh          = '0;
    for (int i = 0; i < NUM_PIX; i++) begin
      o_col_nxt[i] = o_col_r[i];
    end
    if (s1_move) begin
      o_px_nxt    = s1_px_r;
      o_py_nxt    = s1_py_r;
      o_last_nxt  = s1_last_r;
      o_drawn_nxt = s1_drawn_r;
      for (int i = 0; i < NUM_PIX; i++) begin
        o_col_nxt[i] = '0;
        if (s1_drawn_r && (4'(i) < eff_w)) begin
          sh           = 3'(eff_w - 4'd1 - 4'(i));
          o_col_nxt[i] = mem_rdata[sh] ? fg_r : bg_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_col_r  <= '0;
      cur_line_r <= '0;
      reject_r   <= 1'b0;
      s1_v_r     <= 1'b0;
      o_v_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_line_r <= cur_line_nxt;
      reject_r   <= reject_nxt;
      s1_v_r     <= s1_v_nxt;
      o_v_r      <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_load_r   <= is_load_nxt;
    is_cursor_r <= is_cursor_nxt;
    code_r      <= code_nxt;
    byte_r      <= byte_nxt;
    col_r       <= col_nxt;
    line_r      <= line_nxt;
    x0_r        <= x0_nxt;
    y0_r        <= y0_nxt;
    row_addr_r  <= row_addr_nxt;
    row_r       <= row_nxt;
    s1_px_r     <= s1_px_nxt;
    s1_py_r     <= s1_py_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_drawn_r  <= s1_drawn_nxt;
    o_px_r      <= o_px_nxt;
    o_py_r      <= o_py_nxt;
    o_last_r    <= o_last_nxt;
    o_drawn_r   <= o_drawn_nxt;
    for (int i = 0; i < NUM_PIX; i++) begin
      o_col_r[i] <= o_col_nxt[i];
    end
  end

  always_comb begin
    out_tdata                    = '0;
    out_tdata[COORD_W-1:0]       = o_px_r;
    out_tdata[2*COORD_W-1:COORD_W] = o_py_r;
    for (int i = 0; i < NUM_PIX; i++) begin
      out_tdata[2*COORD_W + COLOR_W*i +: COLOR_W] = o_col_r[i];
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_drawn_r;

endmodule

// ===== hw/rtl/brf_glyph_store.sv =====
// ----------------------------------------------------------------------------
// brf_glyph_store
// Byte-wide glyph memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module brf_glyph_store import brf_pkg::*; #(
  parameter int DEPTH = DEF_STORE_BYTES,
  parameter int AW    = $clog2(DEF_STORE_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/brf_addr_reduce.sv =====
// ----------------------------------------------------------------------------
// brf_addr_reduce
// Address reduction modulo the store size: a mask when the store size is a
// power of two, else a reciprocal multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module brf_addr_reduce import brf_pkg::*; #(
  parameter int STORE_BYTES = DEF_STORE_BYTES,
  parameter int AW          = $clog2(DEF_STORE_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  red_req_t      req,
  output logic          done,
  output logic [AW-1:0] rem
);

  localparam bit            POW2  = (STORE_BYTES & (STORE_BYTES - 1)) == 0;
  localparam int            DW    = VW + AW;
  localparam int            MW    = (VW >= AW) ? VW - AW + 1 : 1;
  localparam logic [MW-1:0] RECIP = MW'((1 << VW) / STORE_BYTES);
  localparam logic [DW-1:0] SB    = DW'(STORE_BYTES);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [VW-1:0]    val_r, val_nxt;
  logic [MW-1:0]    quo_r, quo_nxt;
  logic [AW-1:0]    acc_r, acc_nxt;
  logic [DW-1:0]    ext;
  logic [VW+MW-1:0] prod;
  logic [DW-1:0]    diff;

  // Quotient estimate is at most one below the true quotient
  always_comb begin
    ext      = DW'(req.value);
    prod     = (VW + MW)'(req.value) * (VW + MW)'(RECIP);
    diff     = DW'(val_r) - DW'(quo_r) * SB;
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    val_nxt  = val_r;
    quo_nxt  = quo_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      if (POW2) begin
        acc_nxt  = ext[AW-1:0];
        done_nxt = 1'b1;
      end else begin
        val_nxt  = req.value;
        quo_nxt  = prod[VW +: MW];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      acc_nxt  = (diff >= SB) ? AW'(diff - SB) : AW'(diff);
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign rem  = acc_r;

endmodule

// ===== hw/rtl/brf_checker.sv =====
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks of the bitmap font text renderer, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker import brf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("stalled result payload changed");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("rejected character result not last or not zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == FUNC_LOAD || in_tuser == FUNC_CURSOR
      || in_tuser == FUNC_AT) |=> !in_tready)
    else $error("input accepted again while an item is in progress");

endmodule

bind bitmap_font_text_renderer brf_checker u_brf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

// ===== verif/bitmap_font_text_renderer_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_tb
// Self-checking bench: loads glyph bytes, draws characters at the cursor and
// at given positions across several register settings, predicts every pixel
// row and compares it field by field with the rows that leave the block.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_tb;
  import brf_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [COORD_W-1:0]              x;
    logic [COORD_W-1:0]              y;
    logic [NUM_PIX-1:0][COLOR_W-1:0] color;
    logic                            last;
    logic                            drawn;
  } glyph_row_t;

  typedef enum int {RDY_ALWAYS, RDY_ALTERNATE, RDY_MOSTLY, RDY_RARELY} ready_mode_t;

  class glyph_scoreboard;
    logic [COLOR_W-1:0] fg, bg;
    logic [3:0]         gw;
    logic [5:0]         gh, gs;
    logic [COORD_W-1:0] sw, sh;
    logic [COORD_W-1:0] cur_col, cur_line;
    logic [7:0]         store [DEF_STORE_BYTES];
    bit                 loaded [DEF_STORE_BYTES];
    glyph_row_t         rows_due [$];
    int                 errors;

    function new();
      fg = RST_FG;
      bg = RST_BG;
      gw = RST_GW;
      gh = RST_GH;
      gs = RST_GS;
      sw = RST_SW;
      sh = RST_SH;
      cur_col = '0;
      cur_line = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FG: fg = val;
        CFG_BG: bg = val;
        CFG_GW: gw = val[3:0];
        CFG_GH: gh = val[5:0];
        CFG_GS: gs = val[5:0];
        CFG_SW: sw = val[COORD_W-1:0];
        CFG_SH: sh = val[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned width_px();
      if (gw == 0) return 1;
      if (gw > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return gw;
    endfunction

    function int unsigned rows_px();
      if (gh == 0) return 1;
      if (gh > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return gh;
    endfunction

    function int unsigned row_addr(int unsigned code, int unsigned r);
      return (code * gs + r) % DEF_STORE_BYTES;
    endfunction

    function bit render(int unsigned col, int unsigned lin, int unsigned code);
      int unsigned w, h, x0, y0;
      logic [7:0]  bits;
      glyph_row_t  row;
      w = width_px();
      h = rows_px();
      x0 = col * w;
      y0 = lin * h;
      if (y0 >= sh) begin
        row = '0;
        row.last = 1'b1;
        rows_due.push_back(row);
        return 1'b0;
      end
      for (int unsigned r = 0; r < h; r++) begin
        bits = store[row_addr(code, r)];
        row.x = COORD_W'(x0);
        row.y = COORD_W'(y0 + r);
        for (int unsigned i = 0; i < NUM_PIX; i++) begin
          if (i < w) row.color[i] = bits[w - 1 - i] ? fg : bg;
          else row.color[i] = '0;
        end
        row.last = (r + 1 == h);
        row.drawn = 1'b1;
        rows_due.push_back(row);
      end
      return 1'b1;
    endfunction

    function void note_input(logic [1:0] func, logic [IN_TDATA_W-1:0] d);
      int unsigned c, l;
      c = 0;
      l = 0;
      case (func)
        FUNC_LOAD: begin
          store[d[20:8]] = d[28:21];
          loaded[d[20:8]] = 1'b1;
        end
        FUNC_CURSOR: begin
          c = cur_col;
          if ((c + 1) * width_px() >= sw) begin
            cur_col = '0;
            cur_line = cur_line + 13'd1;
          end
          if (render(cur_col, cur_line, d[7:0])) cur_col = cur_col + 13'd1;
        end
        FUNC_AT: begin
          c = d[41:29];
          l = d[54:42];
          if ((c + 1) * width_px() >= sw) begin
            c = 0;
            l = l + 1;
          end
          void'(render(c, l, d[7:0]));
        end
        default: ;
      endcase
    endfunction

    function void check_row(logic [OUT_TDATA_W-1:0] d, logic last, logic drawn);
      glyph_row_t got, want;
      got.x = d[12:0];
      got.y = d[25:13];
      for (int i = 0; i < NUM_PIX; i++) got.color[i] = d[26 + 24 * i +: 24];
      got.last = last;
      got.drawn = drawn;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected row: x=%0d y=%0d colors=%h last=%0b drawn=%0b",
                   got.x, got.y, got.color, got.last, got.drawn);
        return;
      end
      want = rows_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
          got.last !== want.last || got.drawn !== want.drawn) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("row mismatch: expected x=%0d y=%0d colors=%h last=%0b drawn=%0b",
                   want.x, want.y, want.color, want.last, want.drawn);
          $display("              actual   x=%0d y=%0d colors=%h last=%0b drawn=%0b",
                   got.x, got.y, got.color, got.last, got.drawn);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  glyph_scoreboard sb;
  int              burst_left;
  int              items_sent;
  bit              hold_request;
  logic [7:0]      code_pool [4];

  bitmap_font_text_renderer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [7:0] code, logic [12:0] addr,
                                                       logic [7:0] b, logic [12:0] col,
                                                       logic [12:0] lin);
    return {1'b0, lin, col, b, addr, code};
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [IN_TDATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(f, d);
    burst_left--;
    if (f != FUNC_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input logic [12:0] addr, input logic [7:0] b);
    send_item(FUNC_LOAD, pack_item(8'($urandom), addr, b, 13'($urandom), 13'($urandom)));
  endtask

  task automatic load_glyph(input logic [7:0] code);
    int unsigned a;
    for (int unsigned r = 0; r < sb.rows_px(); r++) begin
      a = sb.row_addr(code, r);
      if (!sb.loaded[a]) send_load(13'(a), 8'($urandom));
    end
  endtask

  task automatic draw_text();
    logic [7:0]  code;
    logic [1:0]  f;
    logic [12:0] col, lin;
    int          count;
    code = ($urandom_range(0, 3) != 0) ? code_pool[$urandom_range(0, 3)] : 8'($urandom);
    load_glyph(code);
    count = $urandom_range(1, 4);
    repeat (count) begin
      f = $urandom_range(0, 1) ? FUNC_CURSOR : FUNC_AT;
      if ($urandom_range(0, 3) != 0)
        col = 13'($urandom_range(0, sb.sw / sb.width_px() + 1));
      else
        col = 13'($urandom);
      if ($urandom_range(0, 3) != 0)
        lin = 13'($urandom_range(0, sb.sh / sb.rows_px() + 1));
      else
        lin = 13'($urandom);
      send_item(f, pack_item(code, 13'($urandom), 8'($urandom), col, lin));
    end
  endtask

  task automatic run_random(input int n);
    int start, sel;
    start = items_sent;
    while (items_sent - start < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) draw_text();
      else if (sel < 92) send_load(13'($urandom), 8'($urandom));
      else send_item(FUNC_UNUSED, IN_TDATA_W'({$urandom, $urandom}));
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (sb.rows_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [23:0] fg, input logic [23:0] bg, input logic [23:0] gw,
                           input logic [23:0] gh, input logic [23:0] gs, input logic [23:0] sw,
                           input logic [23:0] sh);
    drain();
    write_cfg(CFG_FG, fg);
    write_cfg(CFG_BG, bg);
    write_cfg(CFG_GW, gw);
    write_cfg(CFG_GH, gh);
    write_cfg(CFG_GS, gs);
    write_cfg(CFG_SW, sw);
    write_cfg(CFG_SH, sh);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: ready pattern changes at random intervals; long hold on request
  initial begin
    ready_mode_t mode;
    int          left;
    out_tready = 1'b0;
    mode = RDY_ALWAYS;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        RDY_ALWAYS:    out_tready <= 1'b1;
        RDY_ALTERNATE: out_tready <= left[0];
        RDY_MOSTLY:    out_tready <= ($urandom_range(0, 3) != 0);
        default:       out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_row(out_tdata, out_tlast, out_tuser);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("bitmap_font_text_renderer_tb failed");
    $finish;
  end

  initial begin
    logic [7:0] patterns [6];
    patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_request = 1'b0;
    burst_left = 0;
    items_sent = 0;
    sb = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, glyph of code 1 at addresses 16..31
    for (int r = 0; r < 16; r++)
      send_load(13'(16 + r), (r < 6) ? patterns[r] : 8'($urandom));
    send_item(FUNC_CURSOR, pack_item(8'd1, '0, '0, '0, '0));
    send_item(FUNC_CURSOR, pack_item(8'd1, '1, '1, '1, '1));
    send_item(FUNC_AT, pack_item(8'd1, '0, '0, 13'd5, 13'd3));
    send_item(FUNC_AT, pack_item(8'd1, '0, '0, 13'h1FFF, 13'd0));
    send_item(FUNC_AT, pack_item(8'd1, '0, '0, 13'd0, 13'h1FFF));
    send_item(FUNC_AT, pack_item(8'd1, '0, '0, 13'h1FFF, 13'h1FFF));
    send_item(FUNC_UNUSED, '1);
    send_load(13'h1FFF, 8'hFF);

    // Small screen: cursor wraps every seven characters; draws can fall off the bottom
    configure(24'($urandom), 24'($urandom), 24'd8, 24'd4, 24'd4, 24'd64, 24'd40);
    code_pool = '{8'd0, 8'd255, 8'($urandom), 8'($urandom)};
    hold_request = 1'b1;
    run_random(12);

    // One-pixel glyphs, every draw wraps
    configure(24'hFFFFFF, 24'h000000, 24'd1, 24'd1, 24'd1, 24'd1, 24'd8191);
    code_pool = '{8'd0, 8'd255, 8'h5A, 8'hA5};
    run_random(8);

    // Zero sizes: width and height act as one, every draw is rejected
    configure(24'h000000, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    run_random(4);

    // Oversized width and height, glyph addresses wrap around the store
    configure(24'($urandom), 24'($urandom), 24'd15, 24'd63, 24'd63, 24'd8191, 24'd8191);
    code_pool = '{8'd255, 8'd255, 8'd131, 8'd131};
    run_random(10);

    // Tall glyphs near the bottom: row coordinate wraps
    configure(24'($urandom), 24'($urandom), 24'd5, 24'd12, 24'd32, 24'd8191, 24'd8191);
    load_glyph(8'd7);
    send_item(FUNC_AT, pack_item(8'd7, '0, '0, 13'd0, 13'd682));
    send_item(FUNC_AT, pack_item(8'd7, '0, '0, 13'd1637, 13'd0));
    send_item(FUNC_AT, pack_item(8'd7, '0, '0, 13'd1638, 13'd0));
    code_pool = '{8'd7, 8'd7, 8'($urandom), 8'($urandom)};
    run_random(5);

    configure(24'($urandom), 24'($urandom), 24'($urandom_range(1, 8)),
              24'($urandom_range(1, 32)), 24'($urandom_range(1, 32)),
              24'($urandom_range(8, 200)), 24'($urandom_range(1, 300)));
    code_pool = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    run_random(10);

    drain();
    if (sb.errors == 0 && sb.rows_due.size() == 0) begin
      $display("bitmap_font_text_renderer_tb passed");
    end else begin
      $display("bitmap_font_text_renderer_tb failed");
    end
    $finish;
  end

endmodule
